@@ rtl/brlt_pkg.sv @@
// Shared types and codes for the block reservation lock table.
// No dependencies; imported by brlt_update, the top level and the testbench.
`default_nettype none

package brlt_pkg;

    // Command codes carried on the input word
    typedef enum logic [1:0] {
        CMD_REGISTER = 2'd0,
        CMD_FORCE    = 2'd1,
        CMD_RESERVE  = 2'd2,
        CMD_RELEASE  = 2'd3
    } t_cmd;

    // Top-level control: clearing sweep after reset, then normal service
    typedef enum logic {
        ST_CLEAR = 1'b0,
        ST_RUN   = 1'b1
    } t_state;

    // Result flags and write strobes from the update logic
    typedef struct packed {
        logic granted;
        logic known;
        logic changed;
        logic red;
        logic wr_map;
        logic wr_ent;
    } t_upd_flags;

endpackage

`default_nettype wire

@@ rtl/brlt_ram.sv @@
// Generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
`default_nettype none

module brlt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read returns the old contents on a same-address write
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/brlt_update.sv @@
// Modify step of the lock table read-modify-write: new entry and result flags.
// Depends on brlt_pkg.
`default_nettype none

module brlt_update #(
    parameter int OWNER_BITS = 8
) (
    input  brlt_pkg::t_cmd       i_cmd,
    input  logic                 i_in_range,
    input  logic                 i_map,
    input  logic                 i_occ,
    input  logic [OWNER_BITS-1:0] i_own,
    input  logic                 i_flag,
    input  logic [OWNER_BITS-1:0] i_req,
    output brlt_pkg::t_upd_flags o_flags,
    output logic                 o_occ,
    output logic [OWNER_BITS-1:0] o_own
);
    import brlt_pkg::*;

    logic                  w_known;
    logic                  w_occ;
    logic [OWNER_BITS-1:0] w_own;
    logic                  w_changed;
    logic                  w_granted;

    assign w_known = i_in_range & i_map;

    always_comb begin
        w_occ     = i_occ;
        w_own     = i_own;
        w_changed = 1'b0;
        w_granted = 1'b0;
        unique case (i_cmd)
            CMD_REGISTER: begin
                w_occ = 1'b0;
                w_own = '0;
            end
            CMD_FORCE: begin
                w_occ     = i_flag;
                w_own     = i_req;
                w_changed = 1'b1;
            end
            CMD_RESERVE: begin
                if (!i_occ || (i_own == i_req)) begin
                    w_occ     = 1'b1;
                    w_own     = i_req;
                    w_changed = 1'b1;
                    w_granted = 1'b1;
                end
            end
            CMD_RELEASE: begin
                if (i_own == i_req) begin
                    w_occ     = 1'b0;
                    w_own     = '0;
                    w_changed = 1'b1;
                end
            end
            default: begin
                w_occ = i_occ;
            end
        endcase
    end

    always_comb begin
        o_flags       = '0;
        o_flags.known = w_known;
        o_occ         = w_occ;
        o_own         = w_own;
        if (i_cmd == CMD_REGISTER) begin
            // register: entry becomes free, nothing reported besides known
            o_flags.wr_map = i_in_range;
            o_flags.wr_ent = i_in_range;
        end else if (!w_known) begin
            // unknown block: reserve always granted, nothing stored
            o_flags.granted = (i_cmd == CMD_RESERVE);
        end else begin
            o_flags.granted = w_granted;
            o_flags.changed = w_changed;
            o_flags.red     = w_occ;
            o_flags.wr_ent  = w_changed;
        end
    end

endmodule

`default_nettype wire

@@ rtl/block_reservation_lock_table_top.sv @@
// Top level of the block reservation lock table: handshake, RMW pipeline,
// forwarding and post-reset clearing sweep. Depends on brlt_pkg, brlt_ram, brlt_update.
`default_nettype none

//  channel  | direction | handshake                  | word
//  ---------+-----------+----------------------------+-------------------------------------
//  command  | in        | i_in_valid / o_in_ready    | cmd, block_index, occupy_flag,
//           |           |                            | requester_id
//  result   | out       | o_out_valid / i_out_ready  | granted, block_known, signal_changed,
//           |           |                            | signal_red, owner_now
//
//  One command word per cycle sustained while the result channel does not stall: the
//  table read is issued at accept, the modify and write-back happen in stage 1 once
//  the result register can take the item, and the result word lands in an output
//  register; the RAM read is registered. After reset every entry of the registered
//  map is swept to zero; the command channel is not ready during the sweep. A stalled
//  result register holds the pipeline stage behind it, and that stage holds o_in_ready low.

module block_reservation_lock_table_top #(
    parameter int BLOCK_COUNT = 256,
    parameter int OWNER_BITS  = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_block_index,
    input  logic       i_occupy_flag,
    input  logic [7:0] i_requester_id,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_granted,
    output logic       o_block_known,
    output logic       o_signal_changed,
    output logic       o_signal_red,
    output logic [7:0] o_owner_now
);
    import brlt_pkg::*;

    localparam int ADDR_W = $clog2(BLOCK_COUNT);
    localparam int ENT_W  = OWNER_BITS + 1;

    // control
    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_clr_addr;
    logic                w_clr_last;

    // stage 1: item whose table read is in flight / returned
    logic                  r_s1_valid;
    t_cmd                  r_s1_cmd;
    logic [ADDR_W-1:0]     r_s1_addr;
    logic                  r_s1_in_range;
    logic                  r_s1_flag;
    logic [OWNER_BITS-1:0] r_s1_req;

    // forwarding of the latest write per memory
    logic                r_fwdm_vld;
    logic [ADDR_W-1:0]   r_fwdm_addr;
    logic                r_fwde_vld;
    logic [ADDR_W-1:0]   r_fwde_addr;
    logic [ENT_W-1:0]    r_fwde_data;

    // result register
    logic       r_out_valid;
    logic       r_out_granted;
    logic       r_out_known;
    logic       r_out_changed;
    logic       r_out_red;
    logic [7:0] r_out_owner;

    logic                  w_accept;
    logic                  w_s1_adv;
    logic [ADDR_W-1:0]     w_in_addr;
    logic                  w_in_range;
    logic                  w_map_rdata;
    logic [ENT_W-1:0]      w_ent_rdata;
    logic                  w_map;
    logic [ENT_W-1:0]      w_ent;
    t_upd_flags            w_flags;
    logic                  w_new_occ;
    logic [OWNER_BITS-1:0] w_new_own;
    logic                  w_map_we;
    logic [ADDR_W-1:0]     w_map_waddr;
    logic                  w_map_wdata;
    logic                  w_ent_we;

    // input decode
    assign w_in_addr  = ADDR_W'(i_block_index);
    assign w_in_range = (32'(i_block_index) < BLOCK_COUNT);

    // handshake
    assign w_s1_adv   = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = (r_state == ST_RUN) && (!r_s1_valid || w_s1_adv);
    assign w_accept   = i_in_valid && o_in_ready;

    // clearing sweep FSM
    assign w_clr_last = (r_clr_addr == ADDR_W'(BLOCK_COUNT - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (w_clr_last) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                n_state = ST_RUN;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // table memories: registered map (swept after reset) and occupancy/owner
    assign w_map_we    = (r_state == ST_CLEAR) || (w_s1_adv && w_flags.wr_map);
    assign w_map_waddr = (r_state == ST_CLEAR) ? r_clr_addr : r_s1_addr;
    assign w_map_wdata = (r_state != ST_CLEAR);
    assign w_ent_we    = w_s1_adv && w_flags.wr_ent;

    brlt_ram #(
        .WIDTH (1),
        .DEPTH (BLOCK_COUNT)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (w_map_we),
        .i_waddr (w_map_waddr),
        .i_wdata (w_map_wdata),
        .i_re    (w_accept),
        .i_raddr (w_in_addr),
        .o_rdata (w_map_rdata)
    );

    brlt_ram #(
        .WIDTH (ENT_W),
        .DEPTH (BLOCK_COUNT)
    ) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (w_ent_we),
        .i_waddr (r_s1_addr),
        .i_wdata ({w_new_occ, w_new_own}),
        .i_re    (w_accept),
        .i_raddr (w_in_addr),
        .o_rdata (w_ent_rdata)
    );

    // stage 1 register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_cmd      <= t_cmd'(i_cmd);
            r_s1_addr     <= w_in_addr;
            r_s1_in_range <= w_in_range;
            r_s1_flag     <= i_occupy_flag;
            r_s1_req      <= OWNER_BITS'(i_requester_id);
        end
    end

    // forwarding: the previous item's write lands on the same edge as this
    // item's read, which returns the old contents
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwdm_vld <= 1'b0;
            r_fwde_vld <= 1'b0;
        end else begin
            if (w_s1_adv && w_flags.wr_map) begin
                r_fwdm_vld <= 1'b1;
            end
            if (w_ent_we) begin
                r_fwde_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv && w_flags.wr_map) begin
            r_fwdm_addr <= r_s1_addr;
        end
        if (w_ent_we) begin
            r_fwde_addr <= r_s1_addr;
            r_fwde_data <= {w_new_occ, w_new_own};
        end
    end

    // map writes in service are always "registered"
    assign w_map = w_map_rdata | (r_fwdm_vld && (r_fwdm_addr == r_s1_addr));
    assign w_ent = (r_fwde_vld && (r_fwde_addr == r_s1_addr)) ? r_fwde_data : w_ent_rdata;

    brlt_update #(
        .OWNER_BITS (OWNER_BITS)
    ) u_update (
        .i_cmd      (r_s1_cmd),
        .i_in_range (r_s1_in_range),
        .i_map      (w_map),
        .i_occ      (w_ent[ENT_W-1]),
        .i_own      (w_ent[OWNER_BITS-1:0]),
        .i_flag     (r_s1_flag),
        .i_req      (r_s1_req),
        .o_flags    (w_flags),
        .o_occ      (w_new_occ),
        .o_own      (w_new_own)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_out_granted <= w_flags.granted;
            r_out_known   <= w_flags.known;
            r_out_changed <= w_flags.changed;
            r_out_red     <= w_flags.red;
            // owner reported only for a known block after a non-register command
            r_out_owner   <= (w_flags.known && (r_s1_cmd != CMD_REGISTER))
                             ? 8'(w_new_own) : 8'd0;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_granted        = r_out_granted;
    assign o_block_known    = r_out_known;
    assign o_signal_changed = r_out_changed;
    assign o_signal_red     = r_out_red;
    assign o_owner_now      = r_out_owner;

endmodule

`default_nettype wire

@@ tb/sv/tb_block_reservation_lock_table_top.sv @@
// Self-checking testbench for the block reservation lock table.
// Drives command words, predicts each result word from a local copy of the table
// and checks it. Depends on brlt_pkg and block_reservation_lock_table_top.
`timescale 1ns / 1ps

module tb_block_reservation_lock_table_top;

    import brlt_pkg::*;

    // Slowest legal run: post-reset sweep, ~1600 words with random gaps and
    // stalls, plus one long receiver hold-off. CYCLE_LIMIT leaves a wide
    // margin over that.
    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 8;     // drain after the last result, with margin
    localparam int IDLE_PERCENT  = 13;
    localparam int HOLDOFF_LEN   = 300;
    localparam int NUM_BLOCKS    = 256;

    // One result word, field for field
    typedef struct packed {
        logic       granted;
        logic       known;
        logic       changed;
        logic       red;
        logic [7:0] owner;
    } t_lock_result;

    // ------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------
    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic [1:0] i_cmd = 2'd0;
    logic [7:0] i_block_index = 8'd0;
    logic       i_occupy_flag = 1'b0;
    logic [7:0] i_requester_id = 8'd0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic       o_granted;
    logic       o_block_known;
    logic       o_signal_changed;
    logic       o_signal_red;
    logic [7:0] o_owner_now;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    block_reservation_lock_table_top DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_cmd            (i_cmd),
        .i_block_index    (i_block_index),
        .i_occupy_flag    (i_occupy_flag),
        .i_requester_id   (i_requester_id),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_granted        (o_granted),
        .o_block_known    (o_block_known),
        .o_signal_changed (o_signal_changed),
        .o_signal_red     (o_signal_red),
        .o_owner_now      (o_owner_now)
    );

    // ------------------------------------------------------------------
    // Local copy of the lock table and the results it predicts
    // ------------------------------------------------------------------
    logic         known_map  [NUM_BLOCKS];
    logic         busy_map   [NUM_BLOCKS];
    logic [7:0]   owner_map  [NUM_BLOCKS];
    t_lock_result pending_results[$];

    int error_count     = 0;
    int words_sent      = 0;
    int results_checked = 0;
    int grants_seen     = 0;
    int events_seen     = 0;
    int cycle_count     = 0;

    // Traffic shaping shared by sender and receiver
    logic no_idle      = 1'b0;   // both sides run flat out while set
    int   rx_hold_left = 0;      // receiver hold-off, counted down below

    // Apply one command to the local table and return the result word it
    // should produce. Occupancy and owner are only consulted for known
    // blocks, and register always writes both first.
    function automatic t_lock_result apply_lock_command(t_cmd cmd, logic [7:0] idx,
                                                        logic flag, logic [7:0] req);
        t_lock_result res;
        res = '0;
        res.known = known_map[idx];
        if (cmd == CMD_REGISTER) begin
            known_map[idx] = 1'b1;
            busy_map[idx]  = 1'b0;
            owner_map[idx] = 8'd0;
        end else if (!res.known) begin
            // unknown block: only reserve says yes, nothing is stored
            res.granted = (cmd == CMD_RESERVE);
        end else begin
            case (cmd)
                CMD_FORCE: begin
                    busy_map[idx]  = flag;
                    owner_map[idx] = req;
                    res.changed    = 1'b1;
                end
                CMD_RESERVE: begin
                    if (!busy_map[idx] || owner_map[idx] == req) begin
                        busy_map[idx]  = 1'b1;
                        owner_map[idx] = req;
                        res.changed    = 1'b1;
                        res.granted    = 1'b1;
                    end
                end
                default: begin
                    // release: owner must match, even on a free block
                    if (owner_map[idx] == req) begin
                        busy_map[idx]  = 1'b0;
                        owner_map[idx] = 8'd0;
                        res.changed    = 1'b1;
                    end
                end
            endcase
            res.red   = busy_map[idx];
            res.owner = owner_map[idx];
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard: everything sampled on pre-edge values at the clock edge.
    // Result check comes before the prediction of the word accepted at the
    // same edge; that word still has two registers to pass, so order never matters.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_lock_result want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result word with no command outstanding");
                    error_count++;
                end else begin
                    want = pending_results.pop_front();
                    results_checked++;
                    if (o_granted !== want.granted) begin
                        $error("granted: expected %0d, got %0d", want.granted, o_granted);
                        error_count++;
                    end
                    if (o_block_known !== want.known) begin
                        $error("block_known: expected %0d, got %0d",
                               want.known, o_block_known);
                        error_count++;
                    end
                    if (o_signal_changed !== want.changed) begin
                        $error("signal_changed: expected %0d, got %0d",
                               want.changed, o_signal_changed);
                        error_count++;
                    end
                    if (o_signal_red !== want.red) begin
                        $error("signal_red: expected %0d, got %0d", want.red, o_signal_red);
                        error_count++;
                    end
                    if (o_owner_now !== want.owner) begin
                        $error("owner_now: expected %0d, got %0d", want.owner, o_owner_now);
                        error_count++;
                    end
                    if (want.granted) grants_seen++;
                    if (want.changed) events_seen++;
                end
            end
            if (i_in_valid && o_in_ready) begin
                pending_results.push_back(apply_lock_command(t_cmd'(i_cmd), i_block_index,
                                                             i_occupy_flag, i_requester_id));
                words_sent++;
            end
        end
    end

    // Receiver: random stalls, a flat-out mode, and a counted hold-off that
    // lets the pipeline fill up and push back on the command channel.
    always @(posedge i_clk) begin
        if (rx_hold_left > 0) begin
            i_out_ready <= 1'b0;
            rx_hold_left--;
        end else if (no_idle) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Command sender. Called at a clock edge; valid is touched once per
    // edge: either dropped for a gap or (re)asserted with the new word.
    // ------------------------------------------------------------------
    task automatic send_command(t_cmd cmd, logic [7:0] idx, logic flag, logic [7:0] req);
        int gap;
        gap = 0;
        while (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_cmd          <= cmd;
        i_block_index  <= idx;
        i_occupy_flag  <= flag;
        i_requester_id <= req;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Random word biased toward a few hot blocks and owners so reserves,
    // refusals and matching releases all happen often.
    task automatic send_random_command(const ref logic [7:0] hot_blocks[8],
                                       const ref logic [7:0] hot_owners[4]);
        int         pick;
        t_cmd       cmd;
        logic [7:0] idx;
        logic [7:0] req;
        pick = $urandom_range(0, 99);
        idx  = ($urandom_range(0, 99) < 75) ? hot_blocks[$urandom_range(0, 7)]
                                            : 8'($urandom);
        req  = ($urandom_range(0, 99) < 80) ? hot_owners[$urandom_range(0, 3)]
                                            : 8'($urandom);
        if (pick < 8)       cmd = CMD_REGISTER;
        else if (pick < 20) cmd = CMD_FORCE;
        else if (pick < 60) cmd = CMD_RESERVE;
        else                cmd = CMD_RELEASE;
        // most releases come from whoever holds the block
        if (cmd == CMD_RELEASE && known_map[idx] && $urandom_range(0, 99) < 60)
            req = owner_map[idx];
        send_command(cmd, idx, 1'($urandom), req);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Corners: unknown blocks, both index extremes, owner ids 0 and all-ones,
    // refused reserve, re-reserve by owner, release mismatch, release of a
    // free block, force both ways, re-register of an occupied block.
    task automatic test_directed();
        send_command(CMD_RESERVE,  8'd0,   1'b0, 8'd7);     // unknown: granted
        send_command(CMD_FORCE,    8'd255, 1'b1, 8'hAA);    // unknown: no effect
        send_command(CMD_RELEASE,  8'd255, 1'b0, 8'd0);     // unknown: no effect
        send_command(CMD_REGISTER, 8'd0,   1'b1, 8'hFF);
        send_command(CMD_REGISTER, 8'd255, 1'b0, 8'h00);
        send_command(CMD_RESERVE,  8'd0,   1'b0, 8'hFF);    // granted
        send_command(CMD_RESERVE,  8'd0,   1'b0, 8'h01);    // refused
        send_command(CMD_RESERVE,  8'd0,   1'b1, 8'hFF);    // same owner again
        send_command(CMD_RELEASE,  8'd0,   1'b0, 8'h01);    // owner mismatch
        send_command(CMD_RELEASE,  8'd0,   1'b0, 8'hFF);    // freed
        send_command(CMD_RELEASE,  8'd0,   1'b1, 8'h00);    // free block, owner 0
        send_command(CMD_RESERVE,  8'd0,   1'b0, 8'h00);    // reserve by owner 0
        send_command(CMD_FORCE,    8'd255, 1'b1, 8'hAA);
        send_command(CMD_FORCE,    8'd255, 1'b0, 8'h55);    // free but owned
        send_command(CMD_RESERVE,  8'd255, 1'b0, 8'h11);    // free: granted
        send_command(CMD_FORCE,    8'd255, 1'b1, 8'h00);
        send_command(CMD_RESERVE,  8'd255, 1'b0, 8'h00);    // owner 0 matches
        send_command(CMD_REGISTER, 8'd255, 1'b1, 8'h3C);    // recreated free
        send_command(CMD_RELEASE,  8'd255, 1'b1, 8'h3C);    // mismatch vs owner 0
        send_command(CMD_RESERVE,  8'h80,  1'b1, 8'h80);    // unknown, high bits
        send_command(CMD_REGISTER, 8'h7F,  1'b0, 8'h7F);
        send_command(CMD_FORCE,    8'h7F,  1'b1, 8'h7F);
        send_command(CMD_RELEASE,  8'h7F,  1'b0, 8'h7F);
    endtask

    // Bulk random traffic with normal idling on both sides
    task automatic test_random_traffic(int count);
        logic [7:0] hot_blocks[8];
        logic [7:0] hot_owners[4];
        hot_blocks[0] = 8'd0;
        hot_blocks[1] = 8'd255;
        for (int i = 2; i < 8; i++) hot_blocks[i] = 8'($urandom);
        hot_owners[0] = 8'd0;
        hot_owners[1] = 8'hFF;
        hot_owners[2] = 8'($urandom);
        hot_owners[3] = 8'($urandom);
        // bring the hot set up first so reserve/release get past the unknown path
        for (int i = 0; i < 8; i++) send_command(CMD_REGISTER, hot_blocks[i], 1'b0, 8'd0);
        for (int i = 0; i < count; i++) send_random_command(hot_blocks, hot_owners);
    endtask

    // Receiver holds off for a long stretch while words keep coming, so the
    // result register and the stage behind it fill and o_in_ready drops.
    task automatic test_output_backpressure(int count);
        logic [7:0] hot_blocks[8];
        logic [7:0] hot_owners[4];
        for (int i = 0; i < 8; i++) hot_blocks[i] = 8'($urandom_range(0, 15));
        for (int i = 0; i < 4; i++) hot_owners[i] = 8'($urandom_range(0, 3));
        no_idle      = 1'b1;
        rx_hold_left = HOLDOFF_LEN;
        for (int i = 0; i < count; i++) send_random_command(hot_blocks, hot_owners);
        no_idle = 1'b0;
    endtask

    // Back-to-back words with no gaps on either side, tight index set so
    // consecutive words hit the same entry (read-after-write forwarding).
    task automatic test_back_to_back(int count);
        logic [7:0] hot_blocks[8];
        logic [7:0] hot_owners[4];
        for (int i = 0; i < 8; i++) hot_blocks[i] = 8'($urandom_range(40, 42));
        hot_owners[0] = 8'd0;
        hot_owners[1] = 8'd1;
        hot_owners[2] = 8'd2;
        hot_owners[3] = 8'hFF;
        no_idle = 1'b1;
        for (int i = 40; i <= 42; i++) send_command(CMD_REGISTER, 8'(i), 1'b0, 8'd0);
        for (int i = 0; i < count; i++) send_random_command(hot_blocks, hot_owners);
        no_idle = 1'b0;
    endtask

    initial begin
        for (int i = 0; i < NUM_BLOCKS; i++) begin
            known_map[i] = 1'b0;
            busy_map[i]  = 1'b0;
            owner_map[i] = 8'd0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // sender just waits out the clearing sweep on o_in_ready

        test_directed();
        test_random_traffic(1100);
        test_output_backpressure(120);
        test_back_to_back(300);

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d command words sent, %0d results checked in %0d cycles",
                 words_sent, results_checked, cycle_count);
        $display("%0d grants and %0d signal events seen, %0d mismatches",
                 grants_seen, events_seen, error_count);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
